### rtl/rmap_target_memory_responder_assert.svh
// Assertion macros used by the RTL top level
`ifndef RMAP_TARGET_MEMORY_RESPONDER_ASSERT_SVH
`define RMAP_TARGET_MEMORY_RESPONDER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define RMAP_ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define RMAP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/rmap_tmr_pkg.sv
package rmap_tmr_pkg;

   localparam int MEM_BYTES    = 65536;
   localparam int MEM_AW       = $clog2(MEM_BYTES);
   localparam int HEADER_BYTES = 12;

   localparam logic [7:0] INSTR_WRITE   = 8'h20;
   localparam logic [7:0] INSTR_REPLY   = 8'h08;
   localparam logic [7:0] INSTR_ALEN    = 8'h03;
   localparam logic [7:0] PROTOCOL_ID   = 8'h01;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;

   // Status codes
   localparam logic [2:0] ST_NONE          = 3'd0;
   localparam logic [2:0] ST_WRITE_DONE    = 3'd1;
   localparam logic [2:0] ST_REPLY_READY   = 3'd2;
   localparam logic [2:0] ST_MALFORMED     = 3'd3;
   localparam logic [2:0] ST_READ_NO_REPLY = 3'd4;
   localparam logic [2:0] ST_WRITE_REPLY   = 3'd5;
   localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd6;

   // Configuration register indexes
   localparam logic [7:0] REG_TARGET_ADDR = 8'd0;
   localparam logic [7:0] REG_PATH_LEN    = 8'd1;
   localparam logic [7:0] REG_SOURCE_ADDR = 8'd2;
   localparam logic [7:0] REG_KEY         = 8'd3;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_STAT,
      KIND_PLAIN,
      KIND_HDR,
      KIND_HCRC,
      KIND_DATA,
      KIND_DCRC
   } kind_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data;
      logic       last;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [2:0] status;
      logic       last;
      logic       crc_clear;
   } stage_type;

   typedef struct packed {
      logic [7:0] target_address;
      logic [3:0] path_length;
      logic [7:0] source_address;
      logic [7:0] required_key;
   } cfg_type;

   // Reflected CRC-8, polynomial x^8+x^2+x+1
   function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ 8'hE0) : (x >> 1);
      end
      return x;
   endfunction

endpackage

### rtl/rmap_tmr_queue.sv
module rmap_tmr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rmap_tmr_pkg::req_type in_item,
   output logic                  out_valid,
   input  logic                  out_pop,
   output rmap_tmr_pkg::req_type out_item
);
   import rmap_tmr_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = out_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold item payloads
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### rtl/rmap_tmr_exec.sv
module rmap_tmr_exec (
   input  logic                    clock,
   input  logic                    reset,
   input  rmap_tmr_pkg::cfg_type   cfg,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  rmap_tmr_pkg::req_type   q_item,
   output logic                    b_valid,
   input  logic                    b_take,
   output rmap_tmr_pkg::stage_type b_item,
   output logic [7:0]              b_rdata
);
   import rmap_tmr_pkg::*;

   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  rdata_ff;

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  instr_ff, instr_in;
   logic [7:0]  init_ff, init_in;
   logic [15:0] trans_ff, trans_in;
   logic [31:0] addr_ff, addr_in;
   logic [23:0] len_ff, len_in;
   logic [24:0] rpos_ff, rpos_in;
   logic        hdr_err_ff, hdr_err_in;
   logic        range_ok_ff, range_ok_in;
   logic [MEM_AW-1:0] rptr_ff, rptr_in;
   logic        b_valid_ff, b_valid_in;
   stage_type   b_ff, b_in;

   logic        adv, wr_en, rd_en;
   logic [16:0] t, pl, r;
   logic [15:0] n;
   logic        hdr_ok;
   logic [24:0] i, sz;
   logic [3:0]  hidx;
   logic [7:0]  hval;

   assign adv     = !b_valid_ff || b_take;
   assign q_pop   = q_valid && adv;
   assign b_valid = b_valid_ff;
   assign b_item  = b_ff;
   assign b_rdata = rdata_ff;

   // Classify and carry out one item
   always_comb begin
      pos_in      = pos_ff;
      instr_in    = instr_ff;
      init_in     = init_ff;
      trans_in    = trans_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      rpos_in     = rpos_ff;
      hdr_err_in  = hdr_err_ff;
      range_ok_in = range_ok_ff;
      rptr_in     = rptr_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      b_in        = '{kind: KIND_NONE, value: ZERO_BYTE, status: ST_NONE,
                      last: 1'b0, crc_clear: 1'b0};
      t      = {1'b0, pos_ff} - 17'(HEADER_BYTES);
      pl     = {13'd0, cfg.path_length};
      r      = pl + 17'd4 + {13'd0, instr_ff[1:0], 2'b00};
      n      = 16'd0;
      hdr_ok = 1'b0;
      i      = rpos_ff - 25'd1;
      sz     = {1'b0, len_ff} + 25'd13;
      hidx   = i[3:0] - 4'd12;
      hval   = ZERO_BYTE;

      if (!q_item.mode) begin
         // Command byte
         b_in.kind = KIND_STAT;
         if (pos_ff == 16'd0) begin
            rpos_in     = 25'd0;
            hdr_err_in  = (q_item.data != ZERO_BYTE);
            range_ok_in = 1'b0;
         end else if (pos_ff >= 16'(HEADER_BYTES)) begin
            if (t == pl) begin
               if (q_item.data != cfg.target_address) hdr_err_in = 1'b1;
            end else if (t == pl + 17'd1) begin
               if (q_item.data != PROTOCOL_ID) hdr_err_in = 1'b1;
            end else if (t == pl + 17'd2) begin
               instr_in = q_item.data;
            end else if (t == pl + 17'd3) begin
               if (q_item.data != cfg.required_key) hdr_err_in = 1'b1;
            end else if (t < pl + 17'd4 || t < r) begin
               // path bytes, ignore
            end else if (t == r) begin
               init_in = q_item.data;
            end else if (t == r + 17'd1 || t == r + 17'd2) begin
               trans_in = {trans_ff[7:0], q_item.data};
            end else if (t == r + 17'd3) begin
               // extended address, ignore
            end else if (t <= r + 17'd7) begin
               addr_in = {addr_ff[23:0], q_item.data};
            end else if (t <= r + 17'd10) begin
               len_in = {len_ff[15:0], q_item.data};
               if (t == r + 17'd10) begin
                  range_ok_in = ({1'b0, addr_ff} + {9'd0, len_in}) <= 33'(MEM_BYTES);
               end
            end else if (t == r + 17'd11) begin
               // header CRC, ignore
            end else if (((instr_ff & INSTR_WRITE) != ZERO_BYTE) && !hdr_err_ff
                         && range_ok_ff && len_ff != 24'd0) begin
               wr_en   = 1'b1;
               addr_in = addr_ff + 32'd1;
               len_in  = len_ff - 24'd1;
            end
         end
         pos_in = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;

         // Decide outcome on the final byte
         if (q_item.last) begin
            n      = pos_in;
            r      = pl + 17'd4 + {13'd0, instr_in[1:0], 2'b00};
            hdr_ok = !hdr_err_in && ({1'b0, n} >= r + 17'(2 * HEADER_BYTES));
            if (!hdr_ok) begin
               b_in.status = ST_MALFORMED;
            end else if (!range_ok_in) begin
               b_in.status = ST_OUT_OF_RANGE;
            end else if ((instr_in & INSTR_WRITE) != ZERO_BYTE) begin
               if (len_in != 24'd0) begin
                  b_in.status = ST_MALFORMED;
               end else if ((instr_in & INSTR_REPLY) != ZERO_BYTE) begin
                  b_in.status = ST_WRITE_REPLY;
               end else begin
                  b_in.status = ST_WRITE_DONE;
               end
            end else if ((instr_in & INSTR_REPLY) != ZERO_BYTE) begin
               b_in.status    = ST_REPLY_READY;
               b_in.crc_clear = 1'b1;
               rpos_in        = 25'd1;
               rptr_in        = addr_in[MEM_AW-1:0];
            end else begin
               b_in.status = ST_READ_NO_REPLY;
            end
            pos_in      = 16'd0;
            hdr_err_in  = 1'b0;
            range_ok_in = 1'b0;
         end
      end else if (rpos_ff != 25'd0) begin
         // Reply byte pull
         rpos_in = rpos_ff + 25'd1;
         if (i < 25'd8) begin
            b_in.kind = KIND_PLAIN;
         end else if (i < 25'd12) begin
            b_in.kind = KIND_PLAIN;
            case (i[1:0])
               2'd0:    b_in.value = {7'd0, sz[24]};
               2'd1:    b_in.value = sz[23:16];
               2'd2:    b_in.value = sz[15:8];
               default: b_in.value = sz[7:0];
            endcase
         end else if (i < 25'd23) begin
            b_in.kind = KIND_HDR;
            case (hidx)
               4'd0:    hval = init_ff;
               4'd1:    hval = PROTOCOL_ID;
               4'd2:    hval = (instr_ff & INSTR_ALEN) | INSTR_REPLY;
               4'd4:    hval = cfg.source_address;
               4'd5:    hval = trans_ff[15:8];
               4'd6:    hval = trans_ff[7:0];
               4'd8:    hval = len_ff[23:16];
               4'd9:    hval = len_ff[15:8];
               4'd10:   hval = len_ff[7:0];
               default: hval = ZERO_BYTE;
            endcase
            b_in.value = hval;
         end else if (i == 25'd23) begin
            b_in.kind = KIND_HCRC;
         end else if (i < 25'd24 + {1'b0, len_ff}) begin
            b_in.kind = KIND_DATA;
            rd_en     = 1'b1;
            rptr_in   = rptr_ff + MEM_AW'(1);
         end else begin
            b_in.kind = KIND_DCRC;
            b_in.last = 1'b1;
            rpos_in   = 25'd0;
         end
      end

      b_valid_in = q_pop ? 1'b1 : (b_take ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         instr_ff    <= '0;
         init_ff     <= '0;
         trans_ff    <= '0;
         addr_ff     <= '0;
         len_ff      <= '0;
         rpos_ff     <= '0;
         hdr_err_ff  <= 1'b0;
         range_ok_ff <= 1'b0;
         rptr_ff     <= '0;
         b_valid_ff  <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (q_pop) begin
            pos_ff      <= pos_in;
            instr_ff    <= instr_in;
            init_ff     <= init_in;
            trans_ff    <= trans_in;
            addr_ff     <= addr_in;
            len_ff      <= len_in;
            rpos_ff     <= rpos_in;
            hdr_err_ff  <= hdr_err_in;
            range_ok_ff <= range_ok_in;
            rptr_ff     <= rptr_in;
         end
      end
   end

   // Hold the stage payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_ff <= b_in;
      end
   end

   // Byte memory: one write or one read per item
   always_ff @(posedge clock) begin
      if (q_pop && wr_en) begin
         mem[addr_ff[MEM_AW-1:0]] <= q_item.data;
      end
      if (q_pop && rd_en) begin
         rdata_ff <= mem[rptr_ff];
      end
   end

endmodule

### rtl/rmap_tmr_reply.sv
module rmap_tmr_reply (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    b_valid,
   output logic                    b_take,
   input  rmap_tmr_pkg::stage_type b_item,
   input  logic [7:0]              b_rdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,
   output logic                    rsp_tlast
);
   import rmap_tmr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   logic [2:0] status_ff, status_in;

   assign b_take     = b_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, status_ff, bvalid_ff, byte_ff};
   assign rsp_tlast  = last_ff;

   // Form the result and run the reply CRC
   always_comb begin
      crc_in    = crc_ff;
      byte_in   = ZERO_BYTE;
      bvalid_in = 1'b1;
      last_in   = b_item.last;
      status_in = ST_NONE;
      case (b_item.kind)
         KIND_NONE: bvalid_in = 1'b0;
         KIND_STAT: begin
            bvalid_in = 1'b0;
            status_in = b_item.status;
            if (b_item.crc_clear) crc_in = ZERO_BYTE;
         end
         KIND_PLAIN: byte_in = b_item.value;
         KIND_HDR: begin
            byte_in = b_item.value;
            crc_in  = crc_step(crc_ff, b_item.value);
         end
         KIND_HCRC: begin
            byte_in = crc_ff;
            crc_in  = ZERO_BYTE;
         end
         KIND_DATA: begin
            byte_in = b_rdata;
            crc_in  = crc_step(crc_ff, b_rdata);
         end
         KIND_DCRC: byte_in = crc_ff;
         default:   bvalid_in = 1'b0;
      endcase
      valid_in = b_take ? 1'b1 : ((valid_ff && rsp_tready) ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (b_take) crc_ff <= crc_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (b_take) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

endmodule

### rtl/rmap_target_memory_responder.sv
// RMAP target with a 64 KiB byte memory behind a stream interface.
// req_ channel: one item per command byte (req_tuser = 0, byte in req_tdata,
// req_tlast on the final byte) or one reply pull (req_tuser = 1).
// rsp_ channel: exactly one result per request item, in order. Command bytes
// return a status (non-zero only on the final byte); pulls return the next
// reply byte with its valid flag, rsp_tlast on the closing data CRC.
// csr_ channel: register writes by index (0 target address, 1 path length,
// 2 source address, 3 key); always ready, write only while the block is idle.
// An accepted request item sits in a two-entry input queue, is then
// registered by the execute stage (header registers and the memory port),
// and then by the result register, where the reply CRC runs. One item per
// cycle is taken in steady state while rsp_tready stays high; the single
// memory port serves a write or a read per item. Reset clears all control
// state and configuration to defaults; the memory keeps its contents. When
// rsp_tready is low the result holds, the pipeline stalls behind it and
// req_tready drops once the queue is full.
module rmap_target_memory_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tuser,   // mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], out_valid[8], status[11:9]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import rmap_tmr_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   req_type   in_item, q_item;
   logic      q_valid, q_pop;
   logic      b_valid, b_take;
   stage_type b_item;
   logic [7:0] b_rdata;

   assign csr_ready = 1'b1;
   assign in_item   = '{mode: req_tuser, data: req_tdata, last: req_tlast};

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TARGET_ADDR: cfg_in.target_address = csr_data;
            REG_PATH_LEN:    cfg_in.path_length    = csr_data[3:0];
            REG_SOURCE_ADDR: cfg_in.source_address = csr_data;
            REG_KEY:         cfg_in.required_key   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{target_address: 8'd254, path_length: 4'd0,
                     source_address: 8'd32, required_key: 8'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rmap_tmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   rmap_tmr_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item),
      .b_valid (b_valid),
      .b_take  (b_take),
      .b_item  (b_item),
      .b_rdata (b_rdata)
   );

   rmap_tmr_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .b_valid    (b_valid),
      .b_take     (b_take),
      .b_item     (b_item),
      .b_rdata    (b_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`include "rmap_target_memory_responder_assert.svh"

   // A reply end marker only comes with a reply byte
   `RMAP_ASSERT_IMPLIES(a_last_has_byte, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[8])
   // A status never comes with a reply byte
   `RMAP_ASSERT_IMPLIES(a_status_no_byte, clock, reset,
      rsp_tvalid && rsp_tdata[11:9] != ST_NONE, !rsp_tdata[8])
   // A result stalled by the receiver holds its end marker
   `RMAP_ASSERT_NEXT(a_hold_last, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tlast == $past(rsp_tlast))

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rmap_tmr_pkg::*;

   localparam bit MODE_CMD  = 1'b0;
   localparam bit MODE_PULL = 1'b1;
   localparam int MEM_SIZE  = 65536;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {
      FLT_NONE,
      FLT_WRAP,
      FLT_TARGET,
      FLT_PROTO,
      FLT_KEY
   } fault_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       dvalid;
      logic [2:0] status;
      logic       last;
   } reply_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   rmap_target_memory_responder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Responder model state
   logic [7:0]  mem_image [0:MEM_SIZE-1];
   bit          mem_known [0:MEM_SIZE-1];
   logic [15:0] rx_pos;
   logic [7:0]  m_instr;
   logic [7:0]  m_initiator;
   logic [15:0] m_tid;
   logic [31:0] m_addr;
   logic [23:0] m_len;
   int unsigned reply_idx;
   logic [7:0]  m_crc;
   bit          hdr_bad;
   bit          in_range;
   logic [7:0]  cfg_target = 8'd254;
   logic [3:0]  cfg_path   = 4'd0;
   logic [7:0]  cfg_source = 8'd32;
   logic [7:0]  cfg_key    = 8'd2;

   reply_item_type reply_expect_q [$];
   int          fail_count = 0;
   int          send_idle = 0;
   int          recv_idle = 0;

   function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      repeat (8) x = x[0] ? ((x >> 1) ^ 8'hE0) : (x >> 1);
      return x;
   endfunction

   function automatic int unsigned path_end();
      return cfg_path + 4 + 4 * (m_instr & INSTR_ALEN);
   endfunction

   // Work out the result of one accepted item and advance the model state
   function automatic reply_item_type predict_reply(input bit mode, input logic [7:0] b,
                                                    input bit last);
      reply_item_type r;
      int unsigned p, t, e, pl, i;
      bit hdr_ok;
      r = '{8'h00, 1'b0, ST_NONE, 1'b0};
      pl = cfg_path;
      if (mode == MODE_CMD) begin
         p = rx_pos;
         if (p == 0) begin
            reply_idx = 0;
            hdr_bad = (b != ZERO_BYTE);
            in_range = 1'b0;
         end else if (p >= HEADER_BYTES) begin
            t = p - HEADER_BYTES;
            e = path_end();
            if (t == pl) begin
               if (b != cfg_target) hdr_bad = 1'b1;
            end else if (t == pl + 1) begin
               if (b != PROTOCOL_ID) hdr_bad = 1'b1;
            end else if (t == pl + 2) begin
               m_instr = b;
            end else if (t == pl + 3) begin
               if (b != cfg_key) hdr_bad = 1'b1;
            end else if (t < pl + 4 || t < e) begin
               // path bytes: ignore
            end else if (t == e) begin
               m_initiator = b;
            end else if (t == e + 1 || t == e + 2) begin
               m_tid = {m_tid[7:0], b};
            end else if (t == e + 3) begin
               // extended address: ignore
            end else if (t <= e + 7) begin
               m_addr = {m_addr[23:0], b};
            end else if (t <= e + 10) begin
               m_len = {m_len[15:0], b};
               if (t == e + 10) in_range = ({32'd0, m_addr} + m_len) <= MEM_SIZE;
            end else if (t == e + 11) begin
               // header CRC: ignore
            end else if ((m_instr & INSTR_WRITE) != 0 && !hdr_bad && in_range && m_len != 0) begin
               mem_image[m_addr[15:0]] = b;
               mem_known[m_addr[15:0]] = 1'b1;
               m_addr++;
               m_len--;
            end
         end
         if (rx_pos != 16'hFFFF) rx_pos++;
         if (last) begin
            hdr_ok = !hdr_bad && rx_pos >= HEADER_BYTES + path_end() + 12;
            if (!hdr_ok) r.status = ST_MALFORMED;
            else if (!in_range) r.status = ST_OUT_OF_RANGE;
            else if ((m_instr & INSTR_WRITE) != 0) begin
               if (m_len != 0) r.status = ST_MALFORMED;
               else r.status = ((m_instr & INSTR_REPLY) != 0) ? ST_WRITE_REPLY : ST_WRITE_DONE;
            end else if ((m_instr & INSTR_REPLY) != 0) begin
               r.status = ST_REPLY_READY;
               reply_idx = 1;
               m_crc = 8'h00;
            end else begin
               r.status = ST_READ_NO_REPLY;
            end
            rx_pos = 0;
            hdr_bad = 1'b0;
            in_range = 1'b0;
         end
      end else if (reply_idx != 0) begin
         i = reply_idx - 1;
         r.dvalid = 1'b1;
         if (i < 8) begin
            r.data = 8'h00;
         end else if (i < 12) begin
            r.data = 8'((m_len + 32'd13) >> ((11 - i) * 8));
         end else if (i < 23) begin
            case (i - 12)
               0:  r.data = m_initiator;
               1:  r.data = PROTOCOL_ID;
               2:  r.data = (m_instr & INSTR_ALEN) | INSTR_REPLY;
               4:  r.data = cfg_source;
               5:  r.data = m_tid[15:8];
               6:  r.data = m_tid[7:0];
               8:  r.data = m_len[23:16];
               9:  r.data = m_len[15:8];
               10: r.data = m_len[7:0];
               default: r.data = ZERO_BYTE;
            endcase
            m_crc = crc8_update(m_crc, r.data);
         end else if (i == 23) begin
            r.data = m_crc;
            m_crc = 8'h00;
         end else if (i < 24 + m_len) begin
            r.data = mem_image[16'(m_addr + (i - 24))];
            m_crc = crc8_update(m_crc, r.data);
         end else begin
            r.data = m_crc;
            r.last = 1'b1;
         end
         reply_idx = r.last ? 0 : reply_idx + 1;
      end
      return r;
   endfunction

   // Drive one item, hold it until taken, then record its expectation
   task automatic send_item(input bit mode, input logic [7:0] b, input bit last);
      reply_item_type exp_item;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      exp_item = predict_reply(mode, b, last);
      reply_expect_q = {reply_expect_q, exp_item};
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (reply_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_TARGET_ADDR: cfg_target = value;
         REG_PATH_LEN:    cfg_path   = value[3:0];
         REG_SOURCE_ADDR: cfg_source = value;
         REG_KEY:         cfg_key    = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] tgt, input logic [3:0] pl,
                             input logic [7:0] src, input logic [7:0] key);
      write_register(REG_TARGET_ADDR, tgt);
      write_register(REG_PATH_LEN, {4'd0, pl});
      write_register(REG_SOURCE_ADDR, src);
      write_register(REG_KEY, key);
   endtask

   // Build a wrapped command and send it; cut_at > 0 ends the packet early
   task automatic send_command(input logic [7:0] instr, input logic [31:0] addr,
                               input logic [23:0] len, input fault_kind_type fault,
                               input int cut_at, input int trailing);
      logic [7:0] pkt [$];
      int n;
      pkt = {pkt, (fault == FLT_WRAP ? 8'($urandom_range(1, 255)) : ZERO_BYTE)};
      repeat (11) pkt = {pkt, 8'($urandom)};
      repeat (cfg_path) pkt = {pkt, 8'($urandom)};
      pkt = {pkt, (fault == FLT_TARGET ? cfg_target ^ 8'($urandom_range(1, 255))
                                       : cfg_target)};
      pkt = {pkt, (fault == FLT_PROTO ? PROTOCOL_ID ^ 8'($urandom_range(1, 255))
                                      : PROTOCOL_ID)};
      pkt = {pkt, instr};
      pkt = {pkt, (fault == FLT_KEY ? cfg_key ^ 8'($urandom_range(1, 255)) : cfg_key)};
      repeat (4 * (instr & INSTR_ALEN)) pkt = {pkt, 8'($urandom)};
      repeat (4) pkt = {pkt, 8'($urandom)};
      for (int k = 3; k >= 0; k--) pkt = {pkt, addr[8*k +: 8]};
      for (int k = 2; k >= 0; k--) pkt = {pkt, len[8*k +: 8]};
      pkt = {pkt, 8'($urandom)};
      if ((instr & INSTR_WRITE) != 0) begin
         repeat (len) pkt = {pkt, 8'($urandom)};
         pkt = {pkt, 8'($urandom)};
      end
      repeat (trailing) pkt = {pkt, 8'($urandom)};
      n = (cut_at > 0 && cut_at < pkt.size()) ? cut_at : pkt.size();
      for (int k = 0; k < n; k++) send_item(MODE_CMD, pkt[k], k == n - 1);
   endtask

   task automatic pull_bytes(input int count);
      repeat (count) send_item(MODE_PULL, 8'($urandom), 1'($urandom));
   endtask

   function automatic bit span_known(input logic [31:0] addr, input int len);
      for (int k = 0; k < len; k++) if (!mem_known[addr + k]) return 1'b0;
      return 1'b1;
   endfunction

   // Pick a read span made only of bytes already written
   function automatic void pick_read_span(output logic [31:0] addr, output logic [23:0] len);
      repeat (8) begin
         len  = $urandom_range(0, 12);
         addr = ($urandom_range(3) == 0) ? MEM_SIZE - 16 + $urandom_range(0, 15)
                                        : $urandom_range(0, 60);
         if (addr + len <= MEM_SIZE && span_known(addr, len)) return;
      end
      addr = $urandom_range(0, 15);
      len  = 24'd0;
   endfunction

   // Check each result against the oldest expectation
   task automatic report_mismatch(input string what, input int expected, input int got);
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, expected, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reply_item_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_expect_q.size() == 0) begin
            report_mismatch("unexpected result", 0, rsp_tdata);
         end else begin
            exp_item = reply_expect_q.pop_front();
            if (rsp_tdata[7:0] !== exp_item.data)
               report_mismatch("out_byte", exp_item.data, rsp_tdata[7:0]);
            if (rsp_tdata[8] !== exp_item.dvalid)
               report_mismatch("out_valid", exp_item.dvalid, rsp_tdata[8]);
            if (rsp_tdata[11:9] !== exp_item.status)
               report_mismatch("status", exp_item.status, rsp_tdata[11:9]);
            if (rsp_tlast !== exp_item.last)
               report_mismatch("out_last", exp_item.last, rsp_tlast);
         end
      end
   end

   // Stall the result side at random
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Seed memory, including the top of the address space, and read it back
   task automatic test_write_read();
      send_command(INSTR_WRITE | 8'h04, 32'd0, 24'd4, FLT_NONE, 0, 0);
      send_command(INSTR_WRITE | INSTR_REPLY | 8'h01, MEM_SIZE - 4, 24'd4, FLT_NONE, 0, 2);
      send_command(INSTR_REPLY | 8'h02, 32'd0, 24'd4, FLT_NONE, 0, 0);
      pull_bytes(4 + 25);
      send_command(INSTR_REPLY, MEM_SIZE - 4, 24'd4, FLT_NONE, 0, 0);
      pull_bytes(4 + 25);
   endtask

   // Header faults, short packets, range errors and reply edge cases
   task automatic test_fault_cases();
      send_command(INSTR_REPLY, 32'd0, 24'd4, FLT_WRAP, 0, 0);
      send_command(INSTR_WRITE, 32'd200, 24'd6, FLT_NONE, 31, 0);
      send_command(INSTR_WRITE, MEM_SIZE - 2, 24'd3, FLT_NONE, 0, 0);
      send_item(MODE_CMD, ZERO_BYTE, 1'b1);
      pull_bytes(2);
      send_command(INSTR_REPLY, 32'd0, 24'd4, FLT_NONE, 0, 0);
      pull_bytes(4 + 25 + 3);
   endtask

   task automatic test_config_extremes();
      set_config(8'd0, 4'd12, 8'd0, 8'd255);
      send_command(INSTR_REPLY | 8'h03, 32'd0, 24'd2, FLT_NONE, 0, 0);
      pull_bytes(2 + 25);
   endtask

   // Mostly well-formed commands with random content, some noise and damage
   task automatic test_random(input int item_budget);
      int pick;
      logic [31:0] addr;
      logic [23:0] len;
      logic [7:0] instr;
      for (int sent = 0; sent < item_budget; ) begin
         pick  = $urandom_range(99);
         instr = 8'($urandom_range(0, 3)) | (8'($urandom) & 8'hD4);
         if (pick < 40) begin
            len  = $urandom_range(0, 8);
            addr = ($urandom_range(4) == 0) ? MEM_SIZE - len : $urandom_range(0, 255);
            send_command(instr | INSTR_WRITE, addr, len, FLT_NONE, 0, $urandom_range(0, 1));
            sent += 30 + len;
         end else if (pick < 75) begin
            pick_read_span(addr, len);
            send_command((instr & ~INSTR_WRITE) | INSTR_REPLY, addr, len, FLT_NONE, 0, 0);
            pull_bytes(($urandom_range(4) == 0) ? $urandom_range(0, 40) : len + 25);
            sent += 55 + len;
         end else if (pick < 82) begin
            send_command(instr & ~(INSTR_WRITE | INSTR_REPLY), 32'($urandom), 24'($urandom),
                         FLT_NONE, 0, 0);
            sent += 30;
         end else if (pick < 88) begin
            len = $urandom_range(1, 8);
            send_command(instr | INSTR_WRITE, MEM_SIZE - len + $urandom_range(1, 4), len,
                         FLT_NONE, 0, 0);
            sent += 35;
         end else if (pick < 94) begin
            send_command(instr | INSTR_WRITE, $urandom_range(0, 255), $urandom_range(1, 8),
                         fault_kind_type'($urandom_range(1, 4)), $urandom_range(0, 40), 0);
            sent += 30;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_item(1'($urandom), 8'($urandom), 1'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < MEM_SIZE; k++) begin
         mem_image[k] = 8'h00;
         mem_known[k] = 1'b0;
      end
      rx_pos = 0; m_instr = 0; m_initiator = 0; m_tid = 0; m_addr = 0; m_len = 0;
      reply_idx = 0; m_crc = 0; hdr_bad = 0; in_range = 0;

      test_write_read();
      test_fault_cases();
      test_config_extremes();
      set_config(8'($urandom), 4'($urandom_range(0, 12)), 8'($urandom), 8'($urandom));
      send_idle = 33; recv_idle = 79;
      test_random(40);
      send_idle = 79; recv_idle = 33;
      test_random(40);
      set_config(8'd254, 4'($urandom_range(0, 12)), 8'($urandom), 8'($urandom));
      send_idle = 0; recv_idle = 0;
      test_random(40);

      wait_drained();
      if (fail_count == 0 && reply_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
